// ===== src/mwtc_pkg.sv =====
// Shared definitions for the selectable-width table CRC engine.
// Holds width codes, register indexes, the 15-bit mask and polynomial lookups.
// No dependencies.
package mwtc_pkg;

    // CRC width codes; any other code runs as 32-bit
    typedef enum logic [1:0] {
        WIDTH_CRC15 = 2'd0,
        WIDTH_CRC16 = 2'd1,
        WIDTH_CRC32 = 2'd2
    } width_mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH_MODE  = 2'd0;
    localparam logic [1:0] CFG_POLY_SELECT = 2'd1;

    localparam logic [31:0] CRC15_MASK = 32'h0000_7FFF;

    // 15-bit polynomial set
    function automatic logic [15:0] poly15(input logic [1:0] sel);
        logic [15:0] p;
        case (sel)
            2'd0:    p = 16'h80CF;
            2'd1:    p = 16'h8437;
            2'd2:    p = 16'h88C7;
            default: p = 16'h99D5;
        endcase
        return p;
    endfunction

    // 16-bit polynomial set
    function automatic logic [15:0] poly16(input logic [1:0] sel);
        logic [15:0] p;
        case (sel)
            2'd0:    p = 16'h80CF;
            2'd1:    p = 16'h84C7;
            2'd2:    p = 16'h88C7;
            default: p = 16'h99D5;
        endcase
        return p;
    endfunction

    // 32-bit polynomial set
    function automatic logic [31:0] poly32(input logic [1:0] sel);
        logic [31:0] p;
        case (sel)
            2'd0:    p = 32'h04C1_1DB7;
            2'd1:    p = 32'h1EDC_6F41;
            2'd2:    p = 32'h741B_8CD7;
            default: p = 32'h8141_41AB;
        endcase
        return p;
    endfunction

endpackage

// ===== src/mwtc_step.sv =====
// One-byte CRC update: builds the table entry for the selected width and
// polynomial, then folds it into the shifted remainder.
// Depends on mwtc_pkg.
module mwtc_step (
    input  logic [7:0]           data_byte,
    input  logic [31:0]          rem_in,
    input  mwtc_pkg::width_mode_t width_mode,
    input  logic [1:0]           poly_select,
    output logic [31:0]          rem_out,
    output logic [31:0]          crc_out
);
    import mwtc_pkg::*;

    always_comb begin
        logic [15:0] r16;
        logic [15:0] t16;
        logic [31:0] t32;
        logic [15:0] p16;
        logic [31:0] p32;
        logic [7:0]  idx;
        r16     = rem_in[15:0];
        t16     = '0;
        t32     = '0;
        p16     = '0;
        p32     = '0;
        idx     = '0;
        rem_out = '0;
        crc_out = '0;
        case (width_mode)
            WIDTH_CRC15: begin
                // 16-bit register, top-bit test on bit 14
                p16 = poly15(poly_select);
                idx = data_byte ^ r16[14:7];
                t16 = {1'b0, idx, 7'd0};
                for (int k = 0; k < 8; k++) begin
                    if (t16[14]) begin
                        t16 = {t16[14:0], 1'b0} ^ p16;
                    end else begin
                        t16 = {t16[14:0], 1'b0};
                    end
                end
                rem_out = {16'd0, t16 ^ {r16[7:0], 8'd0}};
                crc_out = rem_out & CRC15_MASK;
            end
            WIDTH_CRC16: begin
                p16 = poly16(poly_select);
                idx = data_byte ^ r16[15:8];
                t16 = {idx, 8'd0};
                for (int k = 0; k < 8; k++) begin
                    if (t16[15]) begin
                        t16 = {t16[14:0], 1'b0} ^ p16;
                    end else begin
                        t16 = {t16[14:0], 1'b0};
                    end
                end
                rem_out = {16'd0, t16 ^ {r16[7:0], 8'd0}};
                crc_out = rem_out;
            end
            default: begin
                // 32-bit, also taken for the unused width code
                p32 = poly32(poly_select);
                idx = data_byte ^ rem_in[31:24];
                t32 = {idx, 24'd0};
                for (int k = 0; k < 8; k++) begin
                    if (t32[31]) begin
                        t32 = {t32[30:0], 1'b0} ^ p32;
                    end else begin
                        t32 = {t32[30:0], 1'b0};
                    end
                end
                rem_out = t32 ^ {rem_in[23:0], 8'd0};
                crc_out = rem_out;
            end
        endcase
    end

endmodule

// ===== src/multi_width_table_crc.sv =====
// Top level of the selectable-width table CRC engine: input register,
// running remainder, result register and configuration registers.
// Depends on mwtc_pkg and mwtc_step.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast
//  m_       | out       | m_tvalid/m_tready  | m_tdata = crc_value
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle unless a last byte waits on a stalled result word;
// a CRC word reaches m_ via the input and result registers. The limit is
// the remainder loop: one table update per cycle through rem_reg.
// Reset (aresetn low, synchronous) clears the remainder, empties both
// stages and sets width 32-bit, polynomial 0. A stalled result word holds
// the last byte of the next message in the input register.
module multi_width_table_crc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] crc_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    import mwtc_pkg::*;

    width_mode_t width_mode_reg;
    logic [1:0]  poly_select_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] crc_next;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        consume;

    assign cfg_ready = 1'b1;

    // Take a configuration word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_mode_reg  <= WIDTH_CRC32;
            poly_select_reg <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH_MODE:  width_mode_reg  <= width_mode_t'(cfg_data);
                CFG_POLY_SELECT: poly_select_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Advance the input register unless a last byte waits on a full output
    assign consume  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mwtc_step u_step (
        .data_byte   (in_byte_reg),
        .rem_in      (rem_reg),
        .width_mode  (width_mode_reg),
        .poly_select (poly_select_reg),
        .rem_out     (rem_next),
        .crc_out     (crc_next)
    );

    // Fold the byte in; clear after the last byte of a message
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (consume) begin
            rem_reg <= in_last_reg ? 32'd0 : rem_next;
        end
    end

    // Hold the finished CRC word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_last_reg) begin
            out_data_reg <= crc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // Remainder starts over after a message ends
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_last_reg |=> rem_reg == 32'd0)
        else $error("remainder not cleared after last byte");

    // A new result word only comes from a last byte
    a_out_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_last_reg) && $past(in_valid_reg))
        else $error("result word without a last byte");

    // Narrow modes keep the upper remainder bits clear
    a_narrow_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && (width_mode_reg == WIDTH_CRC15 || width_mode_reg == WIDTH_CRC16)
        |=> rem_reg[31:16] == 16'd0)
        else $error("narrow remainder has upper bits set");

    // A last byte never overwrites an unaccepted result word
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(consume && in_last_reg))
        else $error("result word overwritten while stalled");
`endif

endmodule

// ===== test/multi_width_table_crc_test.sv =====
// Self-checking testbench for multi_width_table_crc: directed and random byte streams
// under changing width and polynomial settings, with stalls on both channels.
// Depends on mwtc_pkg and the multi_width_table_crc RTL.
module multi_width_table_crc_test;
    import mwtc_pkg::*;

    // Tracks the running remainder and configuration, and holds the CRC words still due.
    class crc_tracker;
        logic [1:0]  width_code;
        logic [1:0]  poly_sel;
        logic [31:0] remainder;
        logic [31:0] expected_crcs[$];
        int          errors;
        logic [31:0] taps15[4] = '{32'h80CF, 32'h8437, 32'h88C7, 32'h99D5};
        logic [31:0] taps16[4] = '{32'h80CF, 32'h84C7, 32'h88C7, 32'h99D5};
        logic [31:0] taps32[4] = '{32'h04C11DB7, 32'h1EDC6F41,
                                   32'h741B8CD7, 32'h814141AB};

        function new();
            width_code = WIDTH_CRC32;
            poly_sel   = 2'd0;
            remainder  = '0;
            errors     = 0;
        endfunction

        // Apply a configuration write; unknown indexes change nothing
        function void write_reg(logic [1:0] index, logic [1:0] value);
            if (index == CFG_WIDTH_MODE) begin
                width_code = value;
            end else if (index == CFG_POLY_SELECT) begin
                poly_sel = value;
            end
        endfunction

        // One table entry: eight shift-and-reduce steps on the leading byte
        function logic [31:0] divide_byte(logic [31:0] dividend, logic [31:0] taps,
                                          int lead, logic [31:0] top_bit,
                                          logic [31:0] keep);
            logic [31:0] r;
            r = (dividend << lead) & keep;
            for (int k = 0; k < 8; k++) begin
                if ((r & top_bit) != 0) begin
                    r = ((r << 1) ^ taps) & keep;
                end else begin
                    r = (r << 1) & keep;
                end
            end
            return r;
        endfunction

        // Fold one accepted byte into the remainder; queue the CRC on the last byte
        function void note_byte(logic [7:0] data, logic last);
            logic [31:0] r;
            logic [31:0] idx;
            logic [31:0] crc;
            if (width_code == WIDTH_CRC15) begin
                r   = remainder & 32'hFFFF;
                idx = (data ^ (r >> 7)) & 32'hFF;
                r   = (divide_byte(idx, taps15[poly_sel], 7, 32'h4000, 32'hFFFF)
                       ^ (r << 8)) & 32'hFFFF;
                crc = r & CRC15_MASK;
            end else if (width_code == WIDTH_CRC16) begin
                r   = remainder & 32'hFFFF;
                idx = (data ^ (r >> 8)) & 32'hFF;
                r   = (divide_byte(idx, taps16[poly_sel], 8, 32'h8000, 32'hFFFF)
                       ^ (r << 8)) & 32'hFFFF;
                crc = r;
            end else begin
                r   = remainder;
                idx = (data ^ (r >> 24)) & 32'hFF;
                r   = divide_byte(idx, taps32[poly_sel], 24, 32'h8000_0000,
                                  32'hFFFF_FFFF) ^ (r << 8);
                crc = r;
            end
            if (last) begin
                remainder = '0;
                expected_crcs.push_back(crc);
            end else begin
                remainder = r;
            end
        endfunction

        // Compare an accepted CRC word with the oldest one due
        function void check_crc(logic [31:0] got);
            logic [31:0] want;
            if (expected_crcs.size() == 0) begin
                $display("%0t: CRC word %08h arrived with none expected", $time, got);
                errors++;
            end else begin
                want = expected_crcs.pop_front();
                if (got !== want) begin
                    $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_crcs.size();
        endfunction
    endclass

    localparam logic [1:0] CFG_SPARE_2   = 2'd2;
    localparam logic [1:0] CFG_SPARE_3   = 2'd3;
    localparam logic [1:0] WIDTH_ALIAS32 = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SEG_BYTES     = 51;
    localparam int SEGMENTS      = 6;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] data_byte
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [31:0] crc_value
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data  = '0;

    crc_tracker crc_sb;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;
    int         idle_mix[4]  = '{0, 85, 0, 12};
    int         stall_mix[4] = '{0, 0, 85, 12};

    multi_width_table_crc u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Observe every handshake and count cycles with no progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                crc_sb.write_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                crc_sb.note_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                crc_sb.check_crc(m_tdata);
            end
        end
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
                || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Abort when nothing moves for too long
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Offer one byte, idling first at the current rate; valid stays high afterwards
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Send a message of random bytes, optionally leaving it open
    task automatic send_message(input int len, input bit close);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, close && (i == len - 1));
        end
    endtask

    // Drop valid, drain all due CRC words and let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (crc_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int len;
        int sent;
        bit leave_open;
        crc_sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: 32-bit, first polynomial
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b1);

        // 15-bit, last polynomial
        settle();
        write_reg(CFG_WIDTH_MODE, WIDTH_CRC15);
        write_reg(CFG_POLY_SELECT, 2'd3);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h00, 1'b1);

        // 16-bit, second polynomial
        settle();
        write_reg(CFG_WIDTH_MODE, WIDTH_CRC16);
        write_reg(CFG_POLY_SELECT, 2'd1);
        send_byte(8'h31, 1'b0);
        send_byte(8'h32, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h80, 1'b1);

        // Width code three runs as 32-bit; writes to unused indexes are dropped
        settle();
        write_reg(CFG_WIDTH_MODE, WIDTH_ALIAS32);
        write_reg(CFG_POLY_SELECT, 2'd2);
        send_byte(8'hFF, 1'b1);
        settle();
        write_reg(CFG_SPARE_2, 2'd0);
        write_reg(CFG_SPARE_3, 2'd1);
        send_byte(8'h01, 1'b1);

        // Switch width in the middle of a message: 32 to 15 to 32 to 16
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        settle();
        write_reg(CFG_WIDTH_MODE, WIDTH_CRC15);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b1);
        send_byte(8'h12, 1'b0);
        settle();
        write_reg(CFG_WIDTH_MODE, WIDTH_CRC32);
        write_reg(CFG_POLY_SELECT, 2'd1);
        send_byte(8'h34, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        settle();
        write_reg(CFG_WIDTH_MODE, WIDTH_CRC16);
        send_byte(8'hC3, 1'b1);

        // Random messages under random settings, one idling mix per phase
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            send_idle_pct  = idle_mix[phase];
            recv_stall_pct = stall_mix[phase];
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                settle();
                write_reg(CFG_WIDTH_MODE, 2'($urandom_range(3)));
                write_reg(CFG_POLY_SELECT, 2'($urandom_range(3)));
                if ($urandom_range(3) == 0) begin
                    write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
                              2'($urandom_range(3)));
                end
                sent = 0;
                while (sent < SEG_BYTES) begin
                    case ($urandom_range(49))
                        0:       len = $urandom_range(33, 64);
                        1, 2, 3, 4, 5, 6, 7, 8, 9:
                                 len = $urandom_range(9, 32);
                        default: len = $urandom_range(1, 8);
                    endcase
                    // Sometimes carry an open message across the next reconfiguration
                    leave_open = (sent + len >= SEG_BYTES) && ($urandom_range(3) == 0);
                    send_message(len, !leave_open);
                    sent += len;
                end
            end
        end

        // Drain and report
        send_idle_pct = 0;
        settle();
        if (crc_sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
